// ===== rtl/ercc_pkg.sv =====
// Package of the exposure row-count calculator.
// Holds the codes, constants and queue entry type; depends on nothing.
package ercc_pkg;

	localparam logic [2:0] MODEL_A       = 3'd0;
	localparam logic [2:0] MODEL_B       = 3'd1;
	localparam logic [2:0] MODEL_C       = 3'd2;
	localparam logic [2:0] MODEL_PASS    = 3'd3;
	localparam logic [2:0] MODEL_GENERIC = 3'd4;

	localparam logic [1:0] KIND_VALUE    = 2'd0;
	localparam logic [1:0] KIND_SHUTTER  = 2'd1;
	localparam logic [1:0] KIND_ERROR    = 2'd2;

	localparam logic [1:0] REG_MODEL     = 2'd0;
	localparam logic [1:0] REG_SPEED     = 2'd1;
	localparam logic [1:0] REG_RES       = 2'd2;

	localparam logic [24:0] CLK_A_FAST   = 25'd26600000;
	localparam logic [24:0] CLK_A_SLOW   = 25'd13300000;
	localparam logic [24:0] CLK_FAST     = 25'd24000000;
	localparam logic [24:0] CLK_SLOW     = 25'd12000000;
	localparam logic [19:0] LOWER_US     = 20'd1000000;
	localparam logic [19:0] MAX_A        = 20'd32766;
	localparam logic [19:0] MAX_B        = 20'd1048575;
	localparam logic [19:0] MAX_C        = 20'd16383;
	localparam logic [19:0] MIN_A        = 20'd3;

	localparam int NUM_W = 48;
	localparam int DEN_W = 36;

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} div_state_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [19:0]      pass_value;
		logic             unit_us;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic             nonpos;
		logic             round_en;
		logic             plus1;
		logic             clamp_lo;
		logic [19:0]      clamp_max;
	} entry_t;

endpackage

// ===== rtl/ercc_if.sv =====
// Channel interfaces of the exposure row-count calculator.
// Depends on nothing; carries valid, ready and the payload of one item.
interface ercc_in_if;
	logic        valid;
	logic        ready;
	logic [19:0] tint_upper;
	logic [19:0] tint_lower;
	logic [12:0] window_width;
	logic [11:0] h_blanking;
	modport source (output valid, tint_upper, tint_lower, window_width, h_blanking, input ready);
	modport sink (input valid, tint_upper, tint_lower, window_width, h_blanking, output ready);
endinterface

interface ercc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [19:0] exposure_value;
	logic        shutter_unit_us;
	modport source (output valid, result_kind, exposure_value, shutter_unit_us, input ready);
	modport sink (input valid, result_kind, exposure_value, shutter_unit_us, output ready);
endinterface

// ===== rtl/ercc_front.sv =====
// Front part: accepts items, applies the model formula and forms the quotient operands.
// Depends on ercc_pkg and ercc_if.
module ercc_front #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [2:0]           sensor_model,
	input  logic                 fast_clock,
	input  logic [1:0]           resolution_mode,
	ercc_in_if.sink              in_ch,
	output logic                 push,
	output ercc_pkg::entry_t     push_entry,
	input  logic                 push_ready
);
	import ercc_pkg::*;

	localparam logic [13:0] MAX_W = (MAX_WIDTH > 8191) ? 14'd8191 : 14'(MAX_WIDTH);

	logic [12:0]        wsat;
	logic [13:0]        w;
	logic [12:0]        tb;
	logic [14:0]        wt;
	logic [14:0]        trow;
	logic signed [15:0] coef;
	logic [24:0]        clkc;
	logic [1:0]         kind;
	logic               round_en, plus1, clamp_lo, is_a;
	logic [19:0]        clamp_max;
	logic [19:0]        lower;

	logic               v_s1;
	logic [44:0]        prod_a_s1;
	logic signed [36:0] prod_c_s1;
	logic [34:0]        prod_d_s1;
	logic [1:0]         kind_s1;
	logic [19:0]        upper_s1;
	logic               unit_s1, round_s1, plus1_s1, lo_s1, is_a_s1;
	logic [19:0]        max_s1;
	logic signed [48:0] sum;

	always_comb begin
		lower = (in_ch.tint_lower == 20'd0) ? 20'd1 : in_ch.tint_lower;
		wsat = ({1'b0, in_ch.window_width} > MAX_W) ? MAX_W[12:0] : in_ch.window_width;
		w = {1'b0, wsat};
		tb = '0;
		wt = '0;
		trow = '0;
		coef = '0;
		clkc = fast_clock ? CLK_FAST : CLK_SLOW;
		kind = KIND_VALUE;
		round_en = 1'b1;
		plus1 = 1'b0;
		clamp_lo = 1'b0;
		is_a = 1'b0;
		clamp_max = MAX_C;
		unique case (sensor_model)
			MODEL_A: begin
				is_a = 1'b1;
				clkc = fast_clock ? CLK_A_FAST : CLK_A_SLOW;
				round_en = 1'b0;
				clamp_lo = 1'b1;
				clamp_max = MAX_A;
				if (resolution_mode > 2'd1) begin
					kind = KIND_ERROR;
				end
				if (resolution_mode == 2'd1) begin
					w = {wsat, 1'b0};
				end
				tb = {1'b0, in_ch.h_blanking} + 13'd94;
				wt = {1'b0, w} + {2'b0, tb};
				trow = wt;
				coef = 16'sd255 - $signed({1'b0, wt});
			end
			MODEL_B: begin
				clamp_max = MAX_B;
				tb = {1'b0, in_ch.h_blanking} + 13'd142;
				if (resolution_mode == 2'd1) begin
					wt = {2'b0, wsat} + 15'd695 + {2'b0, tb};
					trow = (wt > 15'd1305) ? wt : 15'd1305;
					coef = 16'sd541;
				end else begin
					wt = {2'b0, wsat} + 15'd369 + {2'b0, tb};
					trow = (wt > 15'd647) ? wt : 15'd647;
					coef = 16'sd199;
				end
			end
			MODEL_C: begin
				plus1 = 1'b1;
				wt = {2'b0, wsat} + 15'd358 + {3'b0, in_ch.h_blanking};
				trow = (wt > 15'd617) ? wt : 15'd617;
				coef = 16'sd180;
			end
			MODEL_PASS: begin
				kind = KIND_SHUTTER;
			end
			default: begin
				tb = (in_ch.h_blanking > 12'd10) ? {1'b0, in_ch.h_blanking - 12'd10} : 13'd0;
				wt = {2'b0, wsat} + 15'd244 + {2'b0, tb};
				trow = (wt > 15'd552) ? wt : 15'd552;
				coef = 16'sd180;
			end
		endcase
	end

	assign in_ch.ready = !v_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			prod_a_s1 <= in_ch.tint_upper * clkc;
			prod_c_s1 <= coef * $signed({1'b0, lower});
			prod_d_s1 <= trow * lower;
			kind_s1 <= kind;
			upper_s1 <= in_ch.tint_upper;
			unit_s1 <= (lower == LOWER_US);
			round_s1 <= round_en;
			plus1_s1 <= plus1;
			lo_s1 <= clamp_lo;
			is_a_s1 <= is_a;
			max_s1 <= clamp_max;
		end
	end

	always_comb begin
		sum = $signed({4'b0, prod_a_s1}) + 49'(prod_c_s1);
		push = v_s1;
		push_entry.kind = kind_s1;
		push_entry.pass_value = (kind_s1 == KIND_SHUTTER) ? upper_s1 : 20'd0;
		push_entry.unit_us = (kind_s1 == KIND_SHUTTER) ? unit_s1 : 1'b0;
		push_entry.num = sum[NUM_W-1:0];
		push_entry.den = {1'b0, prod_d_s1};
		push_entry.nonpos = is_a_s1 && (sum <= 49'sd0);
		push_entry.round_en = round_s1;
		push_entry.plus1 = plus1_s1;
		push_entry.clamp_lo = lo_s1;
		push_entry.clamp_max = max_s1;
	end
endmodule

// ===== rtl/ercc_fifo.sv =====
// Two-entry queue between the front and back parts.
// Depends on ercc_pkg.
module ercc_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ercc_pkg::entry_t push_entry,
	output logic             push_ready,
	output logic             pop_valid,
	output ercc_pkg::entry_t pop_entry,
	input  logic             pop
);
	import ercc_pkg::*;

	entry_t     mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_entry = mem_q[rd_q];
	assign do_push = push && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_entry;
		end
	end
endmodule

// ===== rtl/ercc_back.sv =====
// Back part: restoring divider of 48 by 36 bits, rounding, clamping and output register.
// Depends on ercc_pkg and ercc_if.
module ercc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	input  ercc_pkg::entry_t pop_entry,
	output logic             pop,
	ercc_out_if.source       out_ch
);
	import ercc_pkg::*;

	div_state_t       state_q, state_d;
	entry_t           ent_q;
	logic [5:0]       cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;
	logic [NUM_W:0]   qsum;
	logic [19:0]      res_value;
	logic             out_valid_q, load_out;
	logic [1:0]       kind_q;
	logic [19:0]      value_q;
	logic             unit_q;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign ge = (rem_sh >= {1'b0, ent_q.den});
	assign pop = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					if (pop_entry.kind == KIND_VALUE && !pop_entry.nonpos) begin
						state_d = ST_DIV;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DIV: begin
				if (cnt_q == 6'(NUM_W - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		qsum = {1'b0, quo_q}
			+ (NUM_W + 1)'(ent_q.round_en && ({rem_q, 1'b0} > {1'b0, ent_q.den}))
			+ (NUM_W + 1)'(ent_q.plus1);
		if (ent_q.kind != KIND_VALUE) begin
			res_value = ent_q.pass_value;
		end else if (ent_q.nonpos) begin
			res_value = MIN_A;
		end else if (qsum > {29'b0, ent_q.clamp_max}) begin
			res_value = ent_q.clamp_max;
		end else if (ent_q.clamp_lo && qsum[19:0] < MIN_A) begin
			res_value = MIN_A;
		end else begin
			res_value = qsum[19:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			ent_q <= pop_entry;
			quo_q <= pop_entry.num;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (state_q == ST_DIV) begin
			cnt_q <= cnt_q + 6'd1;
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? DEN_W'(rem_sh - {1'b0, ent_q.den}) : rem_sh[DEN_W-1:0];
		end
		if (load_out) begin
			kind_q <= ent_q.kind;
			value_q <= res_value;
			unit_q <= ent_q.unit_us;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.result_kind = kind_q;
	assign out_ch.exposure_value = value_q;
	assign out_ch.shutter_unit_us = unit_q;

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q < 6'(NUM_W))
		else $error("divider step count overran");
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> ent_q.den != '0)
		else $error("division started with a zero divisor");
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && ent_q.kind == KIND_ERROR |-> res_value == 20'd0 && !ent_q.unit_us)
		else $error("error item carries a value");
	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_valid_q && !out_ch.ready |=> state_q == ST_DONE)
		else $error("result left the divider while the output was full");
endmodule

// ===== rtl/exposure_row_count_calc_unit.sv =====
// Top level of the exposure row-count calculator: configuration registers and the three parts.
// Depends on ercc_pkg, ercc_if, ercc_front, ercc_fifo and ercc_back.
//
// Channel   Dir  Payload
// in_ch     in   tint_upper, tint_lower, window_width, h_blanking
// out_ch    out  result_kind, exposure_value, shutter_unit_us
// APB       in   sensor_model, clock select, resolution_mode at 0x0, 0x4, 0x8
//
// An item needing a quotient occupies the divider for a load, 48 restoring steps and an unload,
// and the divider takes no new item until it has handed the last one to the output register.
// Passthrough and error items skip the restoring steps.
// The front and a two-entry queue keep accepting while the divider is busy, until the queue is
// full. Reset clears all control state and sets the configuration registers to their defaults.
module exposure_row_count_calc_unit #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	ercc_in_if.sink     in_ch,
	ercc_out_if.source  out_ch
);
	import ercc_pkg::*;

	logic [2:0] model_q;
	logic       speed_q;
	logic [1:0] res_q;
	logic       push, push_ready, pop_valid, pop;
	entry_t     push_entry, pop_entry;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q <= MODEL_GENERIC;
			speed_q <= 1'b1;
			res_q <= 2'd1;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_MODEL: model_q <= pwdata[2:0];
				REG_SPEED: speed_q <= pwdata[0];
				REG_RES: res_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MODEL: prdata = {29'b0, model_q};
			REG_SPEED: prdata = {31'b0, speed_q};
			REG_RES: prdata = {30'b0, res_q};
			default: prdata = 32'b0;
		endcase
	end

	ercc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.sensor_model(model_q), .fast_clock(speed_q), .resolution_mode(res_q),
		.in_ch(in_ch), .push(push), .push_entry(push_entry), .push_ready(push_ready)
	);

	ercc_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_entry(push_entry), .push_ready(push_ready),
		.pop_valid(pop_valid), .pop_entry(pop_entry), .pop(pop)
	);

	ercc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.pop_valid(pop_valid), .pop_entry(pop_entry), .pop(pop), .out_ch(out_ch)
	);
endmodule

// ===== bench/exposure_row_count_calc_unit_tb.sv =====
// Testbench of the exposure row-count calculator: a directed table, then random phases.
// Each result is checked against the table's expected value or an in-bench prediction.
// Depends on ercc_pkg, ercc_if and exposure_row_count_calc_unit.
`timescale 1ns / 1ps

module exposure_row_count_calc_unit_tb;
	import ercc_pkg::*;

	localparam int WIDTH_CAP = 4096;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		logic [1:0]  kind;
		logic [19:0] value;
		logic        unit_us;
	} exposure_t;

	typedef struct {
		int          model;
		int          speed;
		int          res;
		int          upper;
		int          lower;
		int          width;
		int          hb;
		bit          typed;
		exposure_t   want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ercc_in_if  in_ch();
	ercc_out_if out_ch();

	logic [2:0] cur_model = 3'd4;
	logic       cur_speed = 1'b1;
	logic [1:0] cur_res = 2'd1;

	exposure_t pending_rows[$];
	int        fail_count = 0;
	int        cycle_count = 0;
	bit        quiet = 1'b0;

	exposure_row_count_calc_unit u_top (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint unsigned div_rnd(longint unsigned n, longint unsigned d, bit rnd);
		longint unsigned q;
		longint unsigned r;
		q = n / d;
		r = n % d;
		if (rnd && 2 * r > d) q++;
		return q;
	endfunction

	function automatic exposure_t predict_rows(logic [19:0] upper, logic [19:0] lower_in,
			logic [12:0] width_in, logic [11:0] hb);
		exposure_t       res;
		longint unsigned lower, width, clk_hz, trow, aq, p1, p2, p4, q;
		longint          w, tb, k, dnum, kl;
		res = '{KIND_VALUE, 20'd0, 1'b0};
		lower = (lower_in == 0) ? 1 : lower_in;
		width = (width_in > WIDTH_CAP) ? WIDTH_CAP : width_in;
		clk_hz = cur_speed ? 24000000 : 12000000;
		case (cur_model)
			MODEL_A: begin
				if (cur_res > 1) begin
					res.kind = KIND_ERROR;
				end else begin
					w = longint'(width) * ((cur_res == 1) ? 2 : 1);
					tb = longint'(hb) + 94;
					k = w + tb - 255;
					dnum = longint'(upper) * (cur_speed ? CLK_A_FAST : CLK_A_SLOW);
					kl = k * longint'(lower);
					if (dnum <= kl) q = 1;
					else q = div_rnd(dnum - kl, longint'(w + tb) * lower, 1'b0);
					if (q < MIN_A) q = MIN_A;
					if (q > MAX_A) q = MAX_A;
					res.value = 20'(q);
				end
			end
			MODEL_B: begin
				p1 = 331; p2 = 38; p4 = 316;
				if (cur_res == 1) begin
					p1 = 673; p2 = 22; p4 = 632;
				end
				aq = width + p1 + p2 + hb + 142;
				trow = (aq > p1 + p4) ? aq : p1 + p4;
				q = div_rnd(upper * clk_hz + (p1 - 132) * lower, trow * lower, 1'b1);
				res.value = 20'((q > MAX_B) ? MAX_B : q);
			end
			MODEL_C: begin
				aq = width + 305 + hb + 53;
				trow = (aq > 617) ? aq : 617;
				q = div_rnd(upper * clk_hz + 180 * lower, trow * lower, 1'b1) + 1;
				res.value = 20'((q > MAX_C) ? MAX_C : q);
			end
			MODEL_PASS: begin
				res.kind = KIND_SHUTTER;
				res.value = upper;
				res.unit_us = (lower == LOWER_US);
			end
			default: begin
				aq = width + 244 + ((hb > 10) ? hb - 10 : 0);
				if (aq <= 552) aq = 552;
				q = div_rnd(upper * clk_hz + 180 * lower, aq * lower, 1'b1);
				res.value = 20'((q > MAX_C) ? MAX_C : q);
			end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
		fail_count++;
	endtask

	task automatic wait_idle();
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_MODEL: cur_model = data[2:0];
			REG_SPEED: cur_speed = data[0];
			default:   cur_res = data[1:0];
		endcase
	endtask

	task automatic set_config(int model, int speed, int res);
		in_ch.valid <= 1'b0;
		wait_idle();
		reg_write(REG_MODEL, model);
		reg_write(REG_SPEED, speed);
		reg_write(REG_RES, res);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_item(logic [19:0] upper, logic [19:0] lower, logic [12:0] width,
			logic [11:0] hb, bit typed, exposure_t want);
		int gap;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.tint_upper <= upper;
		in_ch.tint_lower <= lower;
		in_ch.window_width <= width;
		in_ch.h_blanking <= hb;
		do @(posedge clk); while (!in_ch.ready);
		pending_rows.push_back(typed ? want : predict_rows(upper, lower, width, hb));
	endtask

	always @(posedge clk) begin
		exposure_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (pending_rows.size() == 0) begin
				report_mismatch("unexpected item, kind", out_ch.result_kind, -1);
			end else begin
				want = pending_rows.pop_front();
				if (out_ch.result_kind !== want.kind)
					report_mismatch("result_kind", out_ch.result_kind, want.kind);
				if (out_ch.exposure_value !== want.value)
					report_mismatch("exposure_value", out_ch.exposure_value, want.value);
				if (out_ch.shutter_unit_us !== want.unit_us)
					report_mismatch("shutter_unit_us", out_ch.shutter_unit_us, want.unit_us);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("exposure_row_count_calc_unit_tb NOT OK");
			$finish;
		end
	end

	initial begin
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (quiet || $urandom_range(0, 1) == 0) begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
	end

	stim_row_t dir_rows[23] = '{
		'{4, 1, 1, 0,       1000,    1,    0,    1, '{KIND_VALUE, 20'd0, 1'b0}},
		'{4, 1, 1, 1048575, 1,       4096, 0,    1, '{KIND_VALUE, 20'd16383, 1'b0}},
		'{4, 1, 1, 1000,    1000,    8191, 4095, 0, '{KIND_VALUE, 20'd0, 1'b0}},
		'{4, 1, 1, 5,       0,       0,    11,   0, '{KIND_VALUE, 20'd0, 1'b0}},
		'{4, 0, 0, 123,     1000,    640,  300,  0, '{KIND_VALUE, 20'd0, 1'b0}},
		'{0, 1, 2, 100,     1000,    640,  0,    1, '{KIND_ERROR, 20'd0, 1'b0}},
		'{0, 0, 3, 100,     1000000, 8191, 4095, 1, '{KIND_ERROR, 20'd0, 1'b0}},
		'{0, 1, 0, 0,       1000,    640,  0,    1, '{KIND_VALUE, 20'd3, 1'b0}},
		'{0, 1, 1, 1048575, 1,       4096, 4095, 1, '{KIND_VALUE, 20'd32766, 1'b0}},
		'{0, 0, 0, 50,      1000,    1,    0,    0, '{KIND_VALUE, 20'd0, 1'b0}},
		'{1, 1, 1, 1048575, 1,       4096, 4095, 1, '{KIND_VALUE, 20'd1048575, 1'b0}},
		'{1, 0, 0, 0,       1000,    1,    0,    0, '{KIND_VALUE, 20'd0, 1'b0}},
		'{1, 1, 3, 500,     1000,    100,  10,   0, '{KIND_VALUE, 20'd0, 1'b0}},
		'{2, 1, 0, 0,       1000,    0,    0,    1, '{KIND_VALUE, 20'd1, 1'b0}},
		'{2, 0, 1, 1048575, 1,       4096, 0,    1, '{KIND_VALUE, 20'd16383, 1'b0}},
		'{2, 1, 1, 33,      1000,    2000, 2000, 0, '{KIND_VALUE, 20'd0, 1'b0}},
		'{3, 1, 1, 1048575, 1000000, 4096, 0,    1, '{KIND_SHUTTER, 20'd1048575, 1'b1}},
		'{3, 0, 0, 0,       1000,    1,    0,    1, '{KIND_SHUTTER, 20'd0, 1'b0}},
		'{3, 1, 1, 777,     0,       8191, 4095, 0, '{KIND_VALUE, 20'd0, 1'b0}},
		'{5, 1, 1, 10,      1000,    100,  5,    0, '{KIND_VALUE, 20'd0, 1'b0}},
		'{6, 0, 2, 10,      1000,    100,  5,    0, '{KIND_VALUE, 20'd0, 1'b0}},
		'{7, 1, 3, 10,      1000,    100,  5,    0, '{KIND_VALUE, 20'd0, 1'b0}},
		'{4, 1, 1, 20,      1000000, 300,  10,   0, '{KIND_VALUE, 20'd0, 1'b0}}
	};

	initial begin
		logic [19:0] upper, lower;
		logic [12:0] width;
		int          phase;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.tint_upper <= '0;
		in_ch.tint_lower <= '0;
		in_ch.window_width <= '0;
		in_ch.h_blanking <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].model != cur_model || dir_rows[i].speed != cur_speed ||
					dir_rows[i].res != cur_res)
				set_config(dir_rows[i].model, dir_rows[i].speed, dir_rows[i].res);
			send_item(20'(dir_rows[i].upper), 20'(dir_rows[i].lower), 13'(dir_rows[i].width),
				12'(dir_rows[i].hb), dir_rows[i].typed, dir_rows[i].want);
		end

		for (phase = 0; phase < 16; phase++) begin
			if (phase == 0) set_config(0, 0, 0);
			else if (phase == 1) set_config(7, 1, 3);
			else set_config($urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 3));
			quiet = (phase == 15);
			repeat (100) begin
				case ($urandom_range(0, 7))
					0:       upper = 20'd0;
					1:       upper = 20'hFFFFF;
					2, 3:    upper = 20'($urandom_range(0, 2000));
					default: upper = 20'($urandom);
				endcase
				case ($urandom_range(0, 5))
					0:       lower = 20'd1000;
					1:       lower = LOWER_US;
					2:       lower = 20'($urandom_range(0, 3));
					default: lower = 20'($urandom);
				endcase
				width = ($urandom_range(0, 1) == 0) ? 13'($urandom_range(1, 4096)) :
					13'($urandom);
				send_item(upper, lower, width, 12'($urandom), 1'b0,
					'{KIND_VALUE, 20'd0, 1'b0});
			end
		end
		in_ch.valid <= 1'b0;

		while (pending_rows.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("exposure_row_count_calc_unit_tb OK");
		end else begin
			$display("exposure_row_count_calc_unit_tb NOT OK");
		end
		$finish;
	end

endmodule
